// ===== hdl/pps_pkg.sv =====
// Shared widths, codes and controller/datapath signal bundles for the priority scheduler.
`default_nettype none
package pps_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int SLOT_W    = 4;
  localparam int ARR_W     = 16;
  localparam int BURST_W   = 16;
  localparam int PRI_W     = 8;
  localparam int TIME_W    = 20;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Task table word: arrival, remaining work, original burst, priority
  localparam int WORD_W = ARR_W + BURST_W + BURST_W + PRI_W;

  // Request function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic scan_start;
    logic scan_rd;
    logic commit;
    logic calc_tat;
    logic calc_wt;
    logic emit;
  } pps_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_tick;
    logic out_free;
  } pps_status_t;

endpackage
`default_nettype wire

// ===== hdl/pps_req_if.sv =====
// Request channel: valid/ready handshake carrying one load or tick request.
`default_nettype none
interface pps_req_if import pps_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [SLOT_W-1:0]  slot;
  logic [ARR_W-1:0]   arrival;
  logic [BURST_W-1:0] burst;
  logic [PRI_W-1:0]   priority_req;

  modport source (output valid, func, slot, arrival, burst, priority_req, input ready);
  modport sink   (input valid, func, slot, arrival, burst, priority_req, output ready);
endinterface
`default_nettype wire

// ===== hdl/pps_res_if.sv =====
// Result channel: valid/ready handshake carrying one scheduling result.
`default_nettype none
interface pps_res_if import pps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              busy_res;
  logic [SLOT_W-1:0] served_slot;
  logic [TIME_W-1:0] end_time;
  logic              finished;
  logic [TIME_W-1:0] turnaround;
  logic [TIME_W-1:0] waiting;

  modport source (output valid, busy_res, served_slot, end_time, finished, turnaround,
                  waiting, input ready);
  modport sink   (input valid, busy_res, served_slot, end_time, finished, turnaround,
                  waiting, output ready);
endinterface
`default_nettype wire

// ===== hdl/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/pps_ctrl.sv =====
// Scheduler controller: sequences load, slot scan, commit and result hand-off.
`default_nettype none
module pps_ctrl import pps_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pps_status_t              status,
  output      pps_cmd_t                 cmd,
  output      logic                     ready,
  output      logic [$clog2(SLOTS)-1:0] scan_addr
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    IDLE, LOAD, SCAN, DRAIN, COMMIT, TAT, WT, EMIT
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (status.in_valid) begin
            cnt   <= '0;
            state <= status.in_tick ? SCAN : LOAD;
          end
        end
        LOAD:   state <= EMIT;
        SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= DRAIN;
          end
        end
        DRAIN:  state <= COMMIT;
        COMMIT: state <= TAT;
        TAT:    state <= WT;
        WT:     state <= EMIT;
        EMIT: begin
          if (status.out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign ready     = (state == IDLE);
  assign scan_addr = cnt;

  always_comb begin
    cmd            = '0;
    cmd.capture    = (state == IDLE) && status.in_valid;
    cmd.scan_start = (state == IDLE) && status.in_valid && status.in_tick;
    cmd.load_wr    = (state == LOAD);
    cmd.scan_rd    = (state == SCAN);
    cmd.commit     = (state == COMMIT);
    cmd.calc_tat   = (state == TAT);
    cmd.calc_wt    = (state == WT);
    cmd.emit       = (state == EMIT) && status.out_free;
  end

endmodule
`default_nettype wire

// ===== hdl/pps_datapath.sv =====
// Scheduler datapath: task table, valid bits, best-task search, time and result registers.
`default_nettype none
module pps_datapath import pps_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire pps_cmd_t                 cmd,
  input  wire logic [$clog2(SLOTS)-1:0] scan_addr,
  output      logic                     out_free,
  pps_req_if.sink                       request,
  pps_res_if.source                     result
);

  localparam int IDX_W = $clog2(SLOTS);

  // Captured request
  logic [SLOT_W-1:0]  slot_q;
  logic [ARR_W-1:0]   arr_q;
  logic [BURST_W-1:0] bur_q;
  logic [PRI_W-1:0]   pri_q;
  logic               in_range;

  // Table state
  logic [SLOTS-1:0]   slot_valid;
  logic [TIME_W-1:0]  cur_time;

  // RAM ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [WORD_W-1:0]  rd_data;

  // Scan pipeline
  logic               rd_vld;
  logic               rd_ok;
  logic [IDX_W-1:0]   rd_idx;
  logic [ARR_W-1:0]   e_arr;
  logic [BURST_W-1:0] e_rem;
  logic [BURST_W-1:0] e_bur;
  logic [PRI_W-1:0]   e_pri;
  logic               eligible;
  logic               better;

  // Best candidate
  logic               found;
  logic [IDX_W-1:0]   best_slot;
  logic [ARR_W-1:0]   best_arr;
  logic [BURST_W-1:0] best_rem;
  logic [BURST_W-1:0] best_bur;
  logic [PRI_W-1:0]   best_pri;

  // Working result
  logic               busy_q;
  logic [SLOT_W-1:0]  srv_q;
  logic [TIME_W-1:0]  end_q;
  logic               fin_q;
  logic [TIME_W-1:0]  tat_q;
  logic [TIME_W-1:0]  wt_q;
  logic [TIME_W-1:0]  end_next;
  logic [TIME_W-1:0]  bur_ext;

  assign in_range = (int'(slot_q) < SLOTS);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_q <= request.slot;
      arr_q  <= request.arrival;
      bur_q  <= request.burst;
      pri_q  <= request.priority_req;
    end
  end

  // Table write: a load fills the whole word, a commit retires one unit of work
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_slot;
    wr_data = {best_arr, best_rem - 1'b1, best_bur, best_pri};
    if (cmd.load_wr) begin
      wr_en   = in_range;
      wr_addr = IDX_W'(slot_q);
      wr_data = {arr_q, bur_q, bur_q, pri_q};
    end else if (cmd.commit) begin
      wr_en   = found;
    end
  end

  pps_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      cur_time   <= '0;
      rd_vld     <= 1'b0;
      found      <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_rd;
      if (cmd.load_wr && in_range) begin
        slot_valid[IDX_W'(slot_q)] <= 1'b1;
      end
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (rd_vld && eligible && better) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        cur_time <= end_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ok  <= slot_valid[scan_addr];
    rd_idx <= scan_addr;
  end

  assign {e_arr, e_rem, e_bur, e_pri} = rd_data;

  assign eligible = rd_ok && (e_rem != '0) && ({{(TIME_W-ARR_W){1'b0}}, e_arr} <= cur_time);
  assign better   = !found || (e_pri < best_pri) ||
                    ((e_pri == best_pri) && (e_arr < best_arr));

  always_ff @(posedge clk) begin
    if (rd_vld && eligible && better) begin
      best_slot <= rd_idx;
      best_arr  <= e_arr;
      best_rem  <= e_rem;
      best_bur  <= e_bur;
      best_pri  <= e_pri;
    end
  end

  // Time saturates at its maximum
  assign end_next = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
  assign bur_ext  = {{(TIME_W-BURST_W){1'b0}}, best_bur};

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      busy_q <= 1'b0;
      srv_q  <= '0;
      end_q  <= cur_time;
      fin_q  <= 1'b0;
      tat_q  <= '0;
      wt_q   <= '0;
    end
    if (cmd.commit) begin
      busy_q <= found;
      srv_q  <= found ? SLOT_W'(best_slot) : '0;
      end_q  <= end_next;
      fin_q  <= found && (best_rem == BURST_W'(1));
    end
    if (cmd.calc_tat) begin
      tat_q <= fin_q ? end_q - {{(TIME_W-ARR_W){1'b0}}, best_arr} : '0;
    end
    if (cmd.calc_wt) begin
      wt_q <= (fin_q && (tat_q >= bur_ext)) ? tat_q - bur_ext : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.emit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.busy_res    <= busy_q;
      result.served_slot <= srv_q;
      result.end_time    <= end_q;
      result.finished    <= fin_q;
      result.turnaround  <= tat_q;
      result.waiting     <= wt_q;
    end
  end

  assign out_free = !result.valid;

endmodule
`default_nettype wire

// ===== hdl/preemptive_priority_scheduler.sv =====
// Top level of the preemptive priority scheduler: controller, datapath and channel glue.
// A load request passes through the LOAD and EMIT states; a tick request passes through SCAN,
// which reads one task-table slot per cycle, then DRAIN, COMMIT, TAT, WT and EMIT.
// One request at a time: a new one is accepted only back in IDLE, after EMIT has found
// the output register free (it may wait on the sink).
// Reset (rst, synchronous): clears all slot valid bits, time to zero, the output valid flag.
`default_nettype none
module preemptive_priority_scheduler import pps_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pps_req_if.sink     request,
  pps_res_if.source   result
);

  localparam int IDX_W = $clog2(SLOTS);

  // Command and status bundles between controller and datapath
  pps_cmd_t          cmd;
  pps_status_t       status;
  logic              ctrl_ready;
  logic              out_free;
  logic [IDX_W-1:0]  scan_addr;

  // The controller acts on a request only in IDLE, where it drives ready, so valid
  // there already means the request is accepted this cycle.
  assign request.ready = ctrl_ready;

  always_comb begin
    status.in_valid = request.valid;
    status.in_tick  = (request.func == FUNC_TICK);
    status.out_free = out_free;
  end

  // Controller: walks load -> emit, or scan -> drain -> commit -> turnaround
  // -> waiting -> emit, and drives the slot address during the scan.
  pps_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .status    (status),
    .cmd       (cmd),
    .ready     (ctrl_ready),
    .scan_addr (scan_addr)
  );

  // Datapath: task table in RAM, valid bits in flops, running best pick
  // (priority, then arrival, then lowest slot by scan order), time counter
  // and the result register that parts the request and result sides.
  pps_datapath #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .scan_addr (scan_addr),
    .out_free  (out_free),
    .request   (request),
    .result    (result)
  );

endmodule
`default_nettype wire
